>>> rtl/parity_channel_id_allocator_unit_assert.svh
// ============================================================================
// Parity channel id allocator - assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ============================================================================
`ifndef PARITY_CHANNEL_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define PARITY_CHANNEL_ID_ALLOCATOR_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define PCID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define PCID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pcid_pkg.sv
// ============================================================================
// Parity channel id allocator - package
// Field widths, command and status codes, used-map word geometry.
// ============================================================================
`default_nettype none

package pcid_pkg;

	localparam int CHAN_W      = 15;
	localparam int CMD_W       = 3;
	localparam int STAT_W      = 3;
	localparam int ID_BITS_DEF = 14;

	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REG   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REL   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CHECK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QRY   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_ALREADY = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTREG  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_INVALID = 3'd4;

	typedef struct packed {
		logic             hit;
		logic             at_end;
		logic [BIT_W-1:0] idx;
	} scan_res_t;

endpackage

`default_nettype wire

>>> rtl/pcid_ram.sv
// ============================================================================
// Parity channel id allocator - generic RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module pcid_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 257,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/pcid_scan.sv
// ============================================================================
// Parity channel id allocator - word scanner
// Masks one used-map word to the ids of one parity inside [lo, hi] and
// finds the lowest free one.
// ============================================================================
`default_nettype none

module pcid_scan #(
	parameter int AW = 9
) (
	input  wire logic [pcid_pkg::WORD_BITS-1:0] rdata,
	input  wire logic [AW-1:0]                  chk_w,
	input  wire logic [pcid_pkg::CHAN_W-1:0]    lo,
	input  wire logic [pcid_pkg::CHAN_W-1:0]    hi,
	input  wire logic                           par,
	output pcid_pkg::scan_res_t                 res
);

	import pcid_pkg::*;

	localparam int GROUP_W = 8;
	localparam int GROUPS  = WORD_BITS / GROUP_W;
	localparam int GW      = $clog2(GROUP_W);
	localparam int GSW     = BIT_W - GW;
	localparam logic [WORD_BITS-1:0] EVEN_BITS = {(WORD_BITS / 2){2'b01}};

	logic [AW-1:0]        wlo;
	logic [AW-1:0]        whi;
	logic [WORD_BITS-1:0] ge_mask;
	logic [WORD_BITS-1:0] le_mask;
	logic [WORD_BITS-1:0] par_mask;
	logic [WORD_BITS-1:0] cand;
	logic [GROUPS-1:0]    gany;
	logic [GW-1:0]        gidx [GROUPS];
	logic [GSW-1:0]       gsel;

	assign wlo      = AW'(lo >> BIT_W);
	assign whi      = AW'(hi >> BIT_W);
	assign ge_mask  = (chk_w == wlo) ? ({WORD_BITS{1'b1}} << lo[BIT_W-1:0])
	                                 : {WORD_BITS{1'b1}};
	assign le_mask  = (chk_w == whi) ? ({WORD_BITS{1'b1}} >> ~hi[BIT_W-1:0])
	                                 : {WORD_BITS{1'b1}};
	assign par_mask = par ? ~EVEN_BITS : EVEN_BITS;
	assign cand     = ~rdata & ge_mask & le_mask & par_mask;

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			gany[g] = |cand[g*GROUP_W +: GROUP_W];
			gidx[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (cand[g*GROUP_W + b]) begin
					gidx[g] = GW'(b);
				end
			end
		end
		gsel = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (gany[g]) begin
				gsel = GSW'(g);
			end
		end
	end

	assign res.hit    = |gany;
	assign res.at_end = (chk_w == whi);
	assign res.idx    = {gsel, gidx[gsel]};

endmodule

`default_nettype wire

>>> rtl/parity_channel_id_allocator_unit.sv
// ============================================================================
// Parity channel id allocator - top level
// Used-bit map of channel ids in a word RAM, with allocate, register,
// release, query and remote id check.
// ============================================================================
// The used map sits in a RAM of 64-bit words, (2^ID_BITS + 66) / 64 words
// deep (257 at ID_BITS = 14), and one transaction is handled at a time.
// After reset a clearing pass writes every word, one per cycle; input
// stays stalled until it is done while server_mode writes are taken.
// Allocate scans the RAM one word per cycle through its single read port,
// and the word that holds the last issued id may be read in both halves
// of the walk. Register, release and query of an id inside the map go
// through read, modify and write back, then result; check, unknown
// commands and ids beyond the map go straight to the result.
// A finished result waits in the output register while the next
// transaction is accepted.
`default_nettype none

`include "parity_channel_id_allocator_unit_assert.svh"

module parity_channel_id_allocator_unit #(
	parameter int ID_BITS = pcid_pkg::ID_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic                         cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pcid_pkg::CMD_W-1:0]   cmd,
	input  wire logic [pcid_pkg::CHAN_W-1:0]  chan_id,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [pcid_pkg::STAT_W-1:0]  status,
	output logic      [pcid_pkg::CHAN_W-1:0]  new_id,
	output logic                              present
);

	import pcid_pkg::*;

	localparam int MAP_DEPTH = (1 << ID_BITS) + 3;
	localparam int NWORDS    = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [CHAN_W-1:0] ID_TOP = CHAN_W'((1 << ID_BITS) + 1);

	localparam logic [2:0] STATE_CLEAR = 3'd0;
	localparam logic [2:0] STATE_IDLE  = 3'd1;
	localparam logic [2:0] STATE_RD    = 3'd2;
	localparam logic [2:0] STATE_MOD   = 3'd3;
	localparam logic [2:0] STATE_SCAN  = 3'd4;
	localparam logic [2:0] STATE_FIN   = 3'd5;

	logic [2:0]           state_q;
	logic [AW-1:0]        clr_w_q;
	logic                 mode_q;
	logic [CHAN_W-1:0]    last_q;
	logic                 out_valid_q;
	logic                 phase_q;
	logic [AW:0]          rd_w_q;
	logic                 chk_v_s1;
	logic [AW-1:0]        chk_w_s1;
	logic [CMD_W-1:0]     cmd_q;
	logic [CHAN_W-1:0]    id_q;
	logic [CHAN_W-1:0]    lo_q;
	logic [CHAN_W-1:0]    hi_q;
	logic [STAT_W-1:0]    res_status_q;
	logic [CHAN_W-1:0]    res_id_q;
	logic                 res_pres_q;
	logic [STAT_W-1:0]    status_q;
	logic [CHAN_W-1:0]    new_id_q;
	logic                 present_q;

	logic                 accept;
	logic                 in_map;
	logic                 par;
	logic [CHAN_W-1:0]    top_ring;
	logic [CHAN_W-1:0]    lo_a;
	logic [CHAN_W-1:0]    lo_b;
	logic [CHAN_W-1:0]    hi_b;
	logic                 a_empty;
	logic [CHAN_W-1:0]    new_lo;
	logic [CHAN_W-1:0]    new_hi;
	logic [AW:0]          whi_x;
	logic                 stop;
	logic                 issue;
	logic                 go_b;
	logic                 out_free;
	logic [CHAN_W-1:0]    hit_id;
	scan_res_t            scan_res;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] id_onehot;
	logic                 id_bit;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != STATE_IDLE);
	assign in_map   = (chan_id <= ID_TOP);
	assign out_free = !out_valid_q || !out_stall;

	// allocate walks the ring of last_q's parity, above last_q, then wraps
	assign par      = last_q[0];
	assign top_ring = ID_TOP - CHAN_W'(1) + CHAN_W'(par);
	assign lo_a     = last_q + CHAN_W'(2);
	assign lo_b     = CHAN_W'(2) + CHAN_W'(par);
	assign hi_b     = last_q - CHAN_W'(2);
	assign a_empty  = (lo_a > top_ring);
	assign new_lo   = (state_q == STATE_IDLE && !a_empty) ? lo_a : lo_b;
	assign new_hi   = (state_q == STATE_IDLE && !a_empty) ? top_ring : hi_b;
	assign whi_x    = (AW + 1)'(hi_q >> BIT_W);

	assign stop  = chk_v_s1 && (scan_res.hit || scan_res.at_end);
	assign issue = (state_q == STATE_SCAN) && !stop && (rd_w_q <= whi_x);
	assign go_b  = (state_q == STATE_SCAN) && stop && !scan_res.hit && !phase_q
	               && (hi_b >= lo_b);
	assign hit_id = (CHAN_W'(chk_w_s1) << BIT_W) | CHAN_W'(scan_res.idx);

	assign id_onehot = WORD_BITS'(1) << id_q[BIT_W-1:0];
	assign id_bit    = ram_rdata[id_q[BIT_W-1:0]];
	assign ram_raddr = (state_q == STATE_RD) ? AW'(id_q >> BIT_W) : rd_w_q[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(id_q >> BIT_W);
		ram_wdata = ram_rdata | id_onehot;
		case (state_q)
			STATE_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_w_q;
				ram_wdata = '0;
			end
			STATE_MOD: begin
				case (cmd_q)
					CMD_REG: begin
						ram_we = !id_bit;
					end
					CMD_REL: begin
						ram_we    = id_bit;
						ram_wdata = ram_rdata & ~id_onehot;
					end
					default: begin
						ram_we = 1'b0;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pcid_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pcid_scan #(
		.AW (AW)
	) u_scan (
		.rdata (ram_rdata),
		.chk_w (chk_w_s1),
		.lo    (lo_q),
		.hi    (hi_q),
		.par   (par),
		.res   (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_CLEAR;
			clr_w_q     <= '0;
			mode_q      <= 1'b0;
			last_q      <= CHAN_W'(4);
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			rd_w_q      <= '0;
			chk_v_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
				last_q <= CHAN_W'(4) + CHAN_W'(cfg_wr_data);
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			chk_v_s1 <= issue;
			if (issue) begin
				rd_w_q <= rd_w_q + (AW + 1)'(1);
			end
			case (state_q)
				STATE_CLEAR: begin
					clr_w_q <= clr_w_q + AW'(1);
					if (clr_w_q == AW'(NWORDS - 1)) begin
						state_q <= STATE_IDLE;
					end
				end
				STATE_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_ALLOC: begin
								state_q <= STATE_SCAN;
								phase_q <= a_empty;
								rd_w_q  <= (AW + 1)'(new_lo >> BIT_W);
							end
							CMD_REG, CMD_REL, CMD_QRY: begin
								state_q <= in_map ? STATE_RD : STATE_FIN;
							end
							default: begin
								state_q <= STATE_FIN;
							end
						endcase
					end
				end
				STATE_RD: begin
					state_q <= STATE_MOD;
				end
				STATE_MOD: begin
					state_q <= STATE_FIN;
				end
				STATE_SCAN: begin
					if (stop) begin
						if (scan_res.hit) begin
							last_q  <= hit_id;
							state_q <= STATE_FIN;
						end else if (go_b) begin
							phase_q <= 1'b1;
							rd_w_q  <= (AW + 1)'(new_lo >> BIT_W);
						end else begin
							state_q <= STATE_FIN;
						end
					end
				end
				STATE_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= STATE_IDLE;
					end
				end
				default: begin
					state_q <= STATE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chk_w_s1 <= rd_w_q[AW-1:0];
		end
		if (state_q == STATE_IDLE && accept) begin
			cmd_q      <= cmd;
			id_q       <= chan_id;
			lo_q       <= new_lo;
			hi_q       <= new_hi;
			res_id_q   <= '0;
			res_pres_q <= 1'b0;
			case (cmd)
				CMD_CHECK: begin
					res_status_q <= (in_map && (chan_id[0] != mode_q)) ? STAT_OK : STAT_INVALID;
				end
				CMD_REG, CMD_REL, CMD_QRY: begin
					res_status_q <= STAT_INVALID;
				end
				default: begin
					res_status_q <= STAT_OK;
				end
			endcase
		end
		if (go_b) begin
			lo_q <= new_lo;
			hi_q <= new_hi;
		end
		if (state_q == STATE_MOD) begin
			case (cmd_q)
				CMD_REG: begin
					res_status_q <= id_bit ? STAT_ALREADY : STAT_OK;
				end
				CMD_REL: begin
					res_status_q <= id_bit ? STAT_OK : STAT_NOTREG;
				end
				default: begin
					res_status_q <= STAT_OK;
					res_pres_q   <= id_bit;
				end
			endcase
		end
		if (state_q == STATE_SCAN && stop && !go_b) begin
			if (scan_res.hit) begin
				res_status_q <= STAT_OK;
				res_id_q     <= hit_id;
			end else begin
				res_status_q <= STAT_NOFREE;
			end
		end
		if (state_q == STATE_FIN && out_free) begin
			status_q  <= res_status_q;
			new_id_q  <= res_id_q;
			present_q <= res_pres_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign new_id    = new_id_q;
	assign present   = present_q;

	`PCID_ASSERT_NOW(a_scan_no_write, state_q == STATE_SCAN, !ram_we, "map written during allocate scan")
	`PCID_ASSERT_NOW(a_chk_in_bounds, chk_v_s1, (AW + 1)'(chk_w_s1) <= whi_x, "scan word past phase bound")
	`PCID_ASSERT_NOW(a_no_reoffer, state_q == STATE_SCAN && chk_v_s1 && scan_res.hit, hit_id != last_q, "allocate offered last issued id")
	`PCID_ASSERT_NEXT(a_fin_to_out, state_q == STATE_FIN && out_free, out_valid_q && state_q == STATE_IDLE, "result not moved to output")

endmodule

`default_nettype wire
